// ===== rtl/selective_repeat_sender_window_assert.svh =====
// assertion macros for the selective repeat sender window
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_ASSERT_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SRSW_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("srsw same-cycle check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define SRSW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("srsw next-cycle check failed");

`endif

// ===== rtl/srsw_pkg.sv =====
// shared types and codes of the selective repeat sender window
package srsw_pkg;

	localparam int WIN_BITS  = 3;
	localparam int KIND_BITS = 2;
	localparam int ACT_BITS  = 3;

	typedef logic [WIN_BITS-1:0]  win_t;
	typedef logic [KIND_BITS-1:0] kind_t;
	typedef logic [ACT_BITS-1:0]  action_t;

	localparam win_t WIN_RESET = 3'd4;

	localparam kind_t KIND_SEND    = 2'd0;
	localparam kind_t KIND_ACK     = 2'd1;
	localparam kind_t KIND_TIMEOUT = 2'd2;

	localparam action_t ACT_REFUSED = 3'd0;
	localparam action_t ACT_SEND    = 3'd1;
	localparam action_t ACT_RESEND  = 3'd2;
	localparam action_t ACT_CORRUPT = 3'd3;
	localparam action_t ACT_OUTSIDE = 3'd4;
	localparam action_t ACT_ACKED   = 3'd5;

endpackage

// ===== rtl/srsw_ifs.sv =====
// channel interfaces: configuration write, event input, result output
interface srsw_cfg_if;
	logic                valid;
	logic                ready;
	srsw_pkg::win_t      data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface srsw_evt_if #(
	parameter int SEQ_BITS = 3,
	parameter int PAY_BITS = 32
);
	logic                valid;
	logic                ready;
	srsw_pkg::kind_t     kind;
	logic [SEQ_BITS-1:0] seq_num;
	logic                checksum_ok;
	logic [PAY_BITS-1:0] payload;

	modport source(output valid, output kind, output seq_num, output checksum_ok,
		output payload, input ready);
	modport sink(input valid, input kind, input seq_num, input checksum_ok,
		input payload, output ready);
endinterface

interface srsw_res_if #(
	parameter int SEQ_BITS = 3,
	parameter int PAY_BITS = 32
);
	logic                valid;
	logic                ready;
	srsw_pkg::action_t   action;
	logic [SEQ_BITS-1:0] pkt_seq;
	logic [PAY_BITS-1:0] pkt_payload;
	logic                start_timer;
	logic                stop_timer;
	logic [SEQ_BITS-1:0] window_base;
	logic [SEQ_BITS-1:0] next_seq;
	logic                window_full;

	modport source(output valid, output action, output pkt_seq, output pkt_payload,
		output start_timer, output stop_timer, output window_base, output next_seq,
		output window_full, input ready);
	modport sink(input valid, input action, input pkt_seq, input pkt_payload,
		input start_timer, input stop_timer, input window_base, input next_seq,
		input window_full, output ready);
endinterface

// ===== rtl/srsw_ram.sv =====
// generic single-write, single-read ram with registered read data
module srsw_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/srsw_ctrl.sv =====
// window sequencer: event decode, slot read-modify-write, base advance, result register
`include "selective_repeat_sender_window_assert.svh"

module srsw_ctrl #(
	parameter int SEQ_COUNT    = 8,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  srsw_pkg::win_t                window_size,
	srsw_evt_if.sink                      evt,
	srsw_res_if.source                    res,
	output logic                          mem_we,
	output logic [$clog2(SEQ_COUNT)-1:0]  mem_waddr,
	output logic [PAYLOAD_BITS:0]         mem_wdata,
	output logic                          mem_re,
	output logic [$clog2(SEQ_COUNT)-1:0]  mem_raddr,
	input  logic [PAYLOAD_BITS:0]         mem_rdata
);

	localparam int SEQ_BITS = $clog2(SEQ_COUNT);
	localparam int CNT_W    = SEQ_BITS + srsw_pkg::WIN_BITS;

	localparam logic [SEQ_BITS-1:0] SEQ_LAST  = SEQ_BITS'(SEQ_COUNT - 1);
	localparam logic [SEQ_BITS:0]   SEQ_CNT_X = (SEQ_BITS + 1)'(SEQ_COUNT);
	localparam logic [CNT_W-1:0]    WIN_MAX   = CNT_W'(SEQ_COUNT - 1);
	localparam logic [CNT_W-1:0]    WIN_MIN   = CNT_W'(1);

	localparam int ST_BITS = 3;
	localparam logic [ST_BITS-1:0] ST_IDLE    = 3'd0;
	localparam logic [ST_BITS-1:0] ST_RDACK   = 3'd1;
	localparam logic [ST_BITS-1:0] ST_ADV_RD  = 3'd2;
	localparam logic [ST_BITS-1:0] ST_ADV_CHK = 3'd3;
	localparam logic [ST_BITS-1:0] ST_RDTO    = 3'd4;

	logic [ST_BITS-1:0]  state_q, state_d;
	logic [SEQ_BITS-1:0] base_q, base_d;
	logic [SEQ_BITS-1:0] next_q, next_d;
	logic [SEQ_BITS-1:0] seq_q, seq_d;

	logic                    res_valid_q;
	srsw_pkg::action_t       action_q;
	logic [SEQ_BITS-1:0]     pkt_seq_q;
	logic [PAYLOAD_BITS-1:0] pkt_payload_q;
	logic                    start_q;
	logic                    stop_q;
	logic [SEQ_BITS-1:0]     window_base_q;
	logic [SEQ_BITS-1:0]     next_seq_q;
	logic                    full_q;

	logic                    load;
	srsw_pkg::action_t       ld_action;
	logic [SEQ_BITS-1:0]     ld_seq;
	logic [PAYLOAD_BITS-1:0] ld_pay;
	logic                    ld_start;
	logic                    ld_stop;

	logic                    acc;
	logic                    out_free;
	logic [CNT_W-1:0]        eff_win;
	logic                    full_now;
	logic                    seq_in_range;
	logic                    in_win;
	logic [SEQ_BITS-1:0]     to_slot;
	logic                    rd_acked;
	logic [PAYLOAD_BITS-1:0] rd_pay;

	function automatic logic [SEQ_BITS-1:0] inc(input logic [SEQ_BITS-1:0] p);
		return (p == SEQ_LAST) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [SEQ_BITS-1:0] span(input logic [SEQ_BITS-1:0] a,
		input logic [SEQ_BITS-1:0] b);
		logic [SEQ_BITS:0] d;
		d = {1'b0, b} - {1'b0, a};
		if (b < a) begin
			d = d + SEQ_CNT_X;
		end
		return d[SEQ_BITS-1:0];
	endfunction

	function automatic logic is_full(input logic [SEQ_BITS-1:0] b,
		input logic [SEQ_BITS-1:0] n, input logic [CNT_W-1:0] w);
		return CNT_W'(span(b, n)) >= w;
	endfunction

	always_comb begin
		eff_win = CNT_W'(window_size);
		if (eff_win < WIN_MIN) begin
			eff_win = WIN_MIN;
		end else if (eff_win > WIN_MAX) begin
			eff_win = WIN_MAX;
		end
	end

	assign acc       = evt.valid && evt.ready;
	assign out_free  = !res_valid_q || res.ready;
	assign evt.ready = (state_q == ST_IDLE) && out_free;

	assign full_now     = is_full(base_q, next_q, eff_win);
	assign seq_in_range = {1'b0, evt.seq_num} < SEQ_CNT_X;
	assign in_win       = seq_in_range && (span(base_q, evt.seq_num) < span(base_q, next_q));
	assign to_slot      = seq_in_range ? evt.seq_num
		: SEQ_BITS'({1'b0, evt.seq_num} - SEQ_CNT_X);
	assign rd_acked     = mem_rdata[PAYLOAD_BITS];
	assign rd_pay       = mem_rdata[PAYLOAD_BITS-1:0];

	always_comb begin
		state_d   = state_q;
		base_d    = base_q;
		next_d    = next_q;
		seq_d     = seq_q;
		mem_we    = 1'b0;
		mem_waddr = next_q;
		mem_wdata = {1'b0, evt.payload};
		mem_re    = 1'b0;
		mem_raddr = to_slot;
		load      = 1'b0;
		ld_action = srsw_pkg::ACT_CORRUPT;
		ld_seq    = '0;
		ld_pay    = '0;
		ld_start  = 1'b0;
		ld_stop   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (evt.kind)
						srsw_pkg::KIND_SEND: begin
							load = 1'b1;
							if (full_now) begin
								ld_action = srsw_pkg::ACT_REFUSED;
							end else begin
								mem_we    = 1'b1;
								ld_action = srsw_pkg::ACT_SEND;
								ld_seq    = next_q;
								ld_pay    = evt.payload;
								ld_start  = 1'b1;
								next_d    = inc(next_q);
							end
						end
						srsw_pkg::KIND_ACK: begin
							if (!evt.checksum_ok) begin
								load = 1'b1;
							end else if (in_win) begin
								mem_re    = 1'b1;
								mem_raddr = evt.seq_num;
								seq_d     = evt.seq_num;
								state_d   = ST_RDACK;
							end else begin
								load      = 1'b1;
								ld_action = srsw_pkg::ACT_OUTSIDE;
								ld_seq    = evt.seq_num;
								ld_stop   = 1'b1;
							end
						end
						srsw_pkg::KIND_TIMEOUT: begin
							mem_re  = 1'b1;
							seq_d   = to_slot;
							state_d = ST_RDTO;
						end
						default: begin
							load = 1'b1;
						end
					endcase
				end
			end
			ST_RDACK: begin
				if (rd_acked) begin
					if (out_free) begin
						load      = 1'b1;
						ld_action = srsw_pkg::ACT_OUTSIDE;
						ld_seq    = seq_q;
						ld_stop   = 1'b1;
						state_d   = ST_IDLE;
					end
				end else begin
					mem_we    = 1'b1;
					mem_waddr = seq_q;
					mem_wdata = {1'b1, rd_pay};
					state_d   = ST_ADV_RD;
				end
			end
			ST_ADV_RD: begin
				if (base_q == next_q) begin
					if (out_free) begin
						load      = 1'b1;
						ld_action = srsw_pkg::ACT_ACKED;
						ld_seq    = seq_q;
						ld_stop   = 1'b1;
						state_d   = ST_IDLE;
					end
				end else begin
					mem_re    = 1'b1;
					mem_raddr = base_q;
					state_d   = ST_ADV_CHK;
				end
			end
			ST_ADV_CHK: begin
				if (rd_acked) begin
					base_d  = inc(base_q);
					state_d = ST_ADV_RD;
				end else if (out_free) begin
					load      = 1'b1;
					ld_action = srsw_pkg::ACT_ACKED;
					ld_seq    = seq_q;
					ld_stop   = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_RDTO: begin
				if (out_free) begin
					load      = 1'b1;
					ld_action = srsw_pkg::ACT_RESEND;
					ld_seq    = seq_q;
					ld_pay    = rd_pay;
					ld_start  = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_q      <= '0;
			next_q      <= '0;
			seq_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			base_q  <= base_d;
			next_q  <= next_d;
			seq_q   <= seq_d;
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			action_q      <= ld_action;
			pkt_seq_q     <= ld_seq;
			pkt_payload_q <= ld_pay;
			start_q       <= ld_start;
			stop_q        <= ld_stop;
			window_base_q <= base_d;
			next_seq_q    <= next_d;
			full_q        <= is_full(base_d, next_d, eff_win);
		end
	end

	assign res.valid       = res_valid_q;
	assign res.action      = action_q;
	assign res.pkt_seq     = pkt_seq_q;
	assign res.pkt_payload = pkt_payload_q;
	assign res.start_timer = start_q;
	assign res.stop_timer  = stop_q;
	assign res.window_base = window_base_q;
	assign res.next_seq    = next_seq_q;
	assign res.window_full = full_q;

	`SRSW_ASSERT_NEXT(a_send_moves_next,
		acc && (evt.kind == srsw_pkg::KIND_SEND) && !full_now, next_q != $past(next_q))
	`SRSW_ASSERT_NEXT(a_base_moves_in_adv, state_q != ST_ADV_CHK, $stable(base_q))
	`SRSW_ASSERT_NOW(a_adv_inside_window, state_q == ST_ADV_CHK, base_q != next_q)
	`SRSW_ASSERT_NOW(a_write_states, mem_we, (state_q == ST_IDLE) || (state_q == ST_RDACK))

endmodule

// ===== rtl/selective_repeat_sender_window.sv =====
// top level of the selective repeat sender window: window register, slot ram, sequencer
// results: send, refused send, corrupt ack and out-of-window ack are loaded into the result
// register from idle; a timeout or an ack of an already acked slot after a read of its slot;
// a recorded ack after that read, a write of its acked bit and the base advance loop
// throughput: one send per cycle while the result output is not stalled; timeouts and acks
// hold off new items until their result is loaded; acks loop on the single ram read port
// reset: window pointers zero, window size 4, no result pending; slot ram is not cleared
module selective_repeat_sender_window #(
	parameter int SEQ_COUNT    = 8,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	srsw_cfg_if.sink   cfg,
	srsw_evt_if.sink   evt,
	srsw_res_if.source res
);

	localparam int SEQ_BITS = $clog2(SEQ_COUNT);

	srsw_pkg::win_t        win_q;
	logic                  mem_we;
	logic [SEQ_BITS-1:0]   mem_waddr;
	logic [PAYLOAD_BITS:0] mem_wdata;
	logic                  mem_re;
	logic [SEQ_BITS-1:0]   mem_raddr;
	logic [PAYLOAD_BITS:0] mem_rdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= srsw_pkg::WIN_RESET;
		end else if (cfg.valid) begin
			win_q <= cfg.data;
		end
	end

	srsw_ram #(
		.WIDTH(PAYLOAD_BITS + 1),
		.DEPTH(SEQ_COUNT)
	) u_slot_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	srsw_ctrl #(
		.SEQ_COUNT   (SEQ_COUNT),
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.window_size(win_q),
		.evt        (evt),
		.res        (res),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

endmodule

// ===== dv/srsw_tb_pkg.sv =====
// item types and window scoreboard for the selective repeat sender testbench
package srsw_tb_pkg;
	import srsw_pkg::*;

	localparam kind_t KIND_UNUSED = 2'd3;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  seq;
		logic        ok;
		logic [31:0] payload;
	} srsw_event_t;

	typedef struct packed {
		action_t     action;
		logic [2:0]  pkt_seq;
		logic [31:0] pkt_payload;
		logic        start_timer;
		logic        stop_timer;
		logic [2:0]  window_base;
		logic [2:0]  next_seq;
		logic        window_full;
	} srsw_result_t;

	class srsw_ledger;
		win_t         window;
		bit [2:0]     base;
		bit [2:0]     nxt;
		bit           acked [8];
		bit           written [8];
		bit [31:0]    store [8];
		srsw_result_t want_q [$];
		int unsigned  errors;
		int unsigned  events_seen;
		int unsigned  by_action [8];

		function new();
			window = WIN_RESET;
			base = 3'd0;
			nxt = 3'd0;
			errors = 0;
			events_seen = 0;
			for (int i = 0; i < 8; i++) begin
				acked[i] = 1'b0;
				written[i] = 1'b0;
				store[i] = 32'd0;
				by_action[i] = 0;
			end
		endfunction

		function bit [2:0] in_flight();
			return nxt - base;
		endfunction

		function bit is_full();
			bit [2:0] lim;
			lim = (window == 3'd0) ? 3'd1 : window;
			return in_flight() >= lim;
		endfunction

		function void note_event(srsw_event_t ev);
			srsw_result_t r;
			bit [2:0] off;
			r = '0;
			r.action = ACT_CORRUPT;
			events_seen++;
			case (ev.kind)
				KIND_SEND: begin
					if (is_full()) begin
						r.action = ACT_REFUSED;
					end else begin
						store[nxt] = ev.payload;
						written[nxt] = 1'b1;
						acked[nxt] = 1'b0;
						r.action = ACT_SEND;
						r.pkt_seq = nxt;
						r.pkt_payload = ev.payload;
						r.start_timer = 1'b1;
						nxt = nxt + 3'd1;
					end
				end
				KIND_ACK: begin
					if (ev.ok) begin
						r.stop_timer = 1'b1;
						r.pkt_seq = ev.seq;
						r.action = ACT_OUTSIDE;
						off = ev.seq - base;
						if (off < in_flight() && !acked[ev.seq]) begin
							acked[ev.seq] = 1'b1;
							r.action = ACT_ACKED;
							for (int n = 0; n < 8 && acked[base]; n++) begin
								acked[base] = 1'b0;
								base = base + 3'd1;
							end
						end
					end
				end
				KIND_TIMEOUT: begin
					r.action = ACT_RESEND;
					r.pkt_seq = ev.seq;
					r.pkt_payload = store[ev.seq];
					r.start_timer = 1'b1;
				end
				default: r.action = ACT_CORRUPT;
			endcase
			r.window_base = base;
			r.next_seq = nxt;
			r.window_full = is_full();
			want_q.push_back(r);
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(srsw_result_t got);
			srsw_result_t want;
			if (want_q.size() == 0) begin
				$display("%0t: result with none expected, actual %0h", $time, got);
				errors++;
				return;
			end
			want = want_q.pop_front();
			by_action[want.action]++;
			check_field("action", 32'(want.action), 32'(got.action));
			check_field("pkt_seq", 32'(want.pkt_seq), 32'(got.pkt_seq));
			check_field("pkt_payload", want.pkt_payload, got.pkt_payload);
			check_field("start_timer", 32'(want.start_timer), 32'(got.start_timer));
			check_field("stop_timer", 32'(want.stop_timer), 32'(got.stop_timer));
			check_field("window_base", 32'(want.window_base), 32'(got.window_base));
			check_field("next_seq", 32'(want.next_seq), 32'(got.next_seq));
			check_field("window_full", 32'(want.window_full), 32'(got.window_full));
		endfunction
	endclass

endpackage

// ===== dv/tb_top.sv =====
// top testbench of the selective repeat sender window: stimulus, handshakes, checking
module tb_top;
	import srsw_pkg::*;
	import srsw_tb_pkg::*;

	localparam int IDLE_LIMIT   = 3000;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 30;
	localparam int PHASE_ITEMS  = 138;

	logic clk;
	logic arst_n;
	bit   calm;
	bit   hold_req;
	int   idle_cycles;
	int   phases_run;

	srsw_ledger ledger;

	srsw_cfg_if cfg_ch();
	srsw_evt_if #(.SEQ_BITS(3), .PAY_BITS(32)) evt_ch();
	srsw_res_if #(.SEQ_BITS(3), .PAY_BITS(32)) res_ch();

	selective_repeat_sender_window #(.SEQ_COUNT(8), .PAYLOAD_BITS(32)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.evt(evt_ch),
		.res(res_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic srsw_event_t pick_event();
		srsw_event_t ev;
		bit [2:0] live [$];
		bit [2:0] sent [$];
		bit [2:0] s;
		int r;
		ev.kind = KIND_SEND;
		ev.seq = 3'($urandom);
		ev.ok = 1'($urandom);
		ev.payload = $urandom;
		for (int i = 0; i < ledger.in_flight(); i++) begin
			s = ledger.base + 3'(i);
			if (!ledger.acked[s])
				live.push_back(s);
		end
		for (int i = 0; i < 8; i++)
			if (ledger.written[i])
				sent.push_back(3'(i));
		r = $urandom_range(0, 99);
		if (r < 40) begin
			case ($urandom_range(0, 9))
				0: ev.payload = 32'd0;
				1: ev.payload = 32'hFFFF_FFFF;
				default: ;
			endcase
		end else if (r < 75) begin
			if (live.size() > 0) begin
				ev.kind = KIND_ACK;
				ev.ok = 1'b1;
				ev.seq = live[$urandom_range(0, live.size() - 1)];
			end
		end else if (r < 85) begin
			if (sent.size() > 0) begin
				ev.kind = KIND_TIMEOUT;
				if (live.size() > 0 && $urandom_range(0, 9) < 7)
					ev.seq = live[$urandom_range(0, live.size() - 1)];
				else
					ev.seq = sent[$urandom_range(0, sent.size() - 1)];
			end
		end else if (r < 90) begin
			ev.kind = KIND_ACK;
			ev.ok = 1'b0;
		end else if (r < 96) begin
			ev.kind = KIND_ACK;
			ev.ok = 1'b1;
		end else begin
			ev.kind = KIND_UNUSED;
		end
		return ev;
	endfunction

	task automatic drive_event(srsw_event_t ev);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			evt_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		evt_ch.valid <= 1'b1;
		evt_ch.kind <= ev.kind;
		evt_ch.seq_num <= ev.seq;
		evt_ch.checksum_ok <= ev.ok;
		evt_ch.payload <= ev.payload;
		do @(posedge clk); while (evt_ch.ready !== 1'b1);
		ledger.note_event(ev);
	endtask

	task automatic put(kind_t k, bit [2:0] s, bit ok, bit [31:0] pay);
		srsw_event_t ev;
		ev.kind = k;
		ev.seq = s;
		ev.ok = ok;
		ev.payload = pay;
		drive_event(ev);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		evt_ch.valid <= 1'b0;
		while (ledger.want_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(win_t w);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= w;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		ledger.window = w;
		phases_run++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// output side: random stalls, one long hold on request
	initial begin
		int stall;
		stall = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall = LONG_HOLD;
			end
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				stall--;
			end else begin
				res_ch.ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			ledger.check_result('{res_ch.action, res_ch.pkt_seq, res_ch.pkt_payload,
				res_ch.start_timer, res_ch.stop_timer, res_ch.window_base,
				res_ch.next_seq, res_ch.window_full});
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, idle_cycles);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		win_t plan [9];
		clk = 1'b0;
		arst_n = 1'b0;
		calm = 1'b0;
		hold_req = 1'b0;
		idle_cycles = 0;
		phases_run = 0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = WIN_RESET;
		evt_ch.valid = 1'b0;
		evt_ch.kind = KIND_SEND;
		evt_ch.seq_num = 3'd0;
		evt_ch.checksum_ok = 1'b0;
		evt_ch.payload = 32'd0;
		plan = '{3'd7, 3'd0, 3'd1, 3'd5, 3'd2, 3'd7, 3'd6, 3'd3, 3'd4};
		ledger = new();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		write_window(3'd4);
		put(KIND_SEND, 3'd7, 1'b1, 32'hFFFF_FFFF);
		put(KIND_SEND, 3'd0, 1'b0, 32'h0000_0000);
		put(KIND_SEND, 3'd3, 1'b1, 32'hA5A5_A5A5);
		put(KIND_SEND, 3'd4, 1'b0, 32'h5A5A_5A5A);
		put(KIND_SEND, 3'd5, 1'b1, 32'h1234_5678);
		put(KIND_ACK, 3'd1, 1'b0, 32'hFFFF_FFFF);
		put(KIND_UNUSED, 3'd1, 1'b1, 32'h0000_0001);
		put(KIND_ACK, 3'd5, 1'b1, 32'h8000_0000);
		put(KIND_ACK, 3'd2, 1'b1, 32'd0);
		put(KIND_ACK, 3'd2, 1'b1, 32'd0);
		put(KIND_TIMEOUT, 3'd0, 1'b0, 32'hDEAD_BEEF);
		put(KIND_TIMEOUT, 3'd2, 1'b1, 32'd0);
		put(KIND_ACK, 3'd0, 1'b1, 32'd0);
		put(KIND_ACK, 3'd1, 1'b1, 32'd0);
		put(KIND_ACK, 3'd3, 1'b1, 32'd0);
		put(KIND_SEND, 3'd0, 1'b0, 32'h0000_0001);
		put(KIND_SEND, 3'd0, 1'b0, 32'h0000_0002);
		put(KIND_SEND, 3'd0, 1'b0, 32'h0000_0004);
		put(KIND_SEND, 3'd0, 1'b0, 32'h0000_0008);
		// shrink below the outstanding count
		wait_drained();
		write_window(3'd1);
		put(KIND_SEND, 3'd0, 1'b0, 32'h0000_0010);
		put(KIND_ACK, 3'd5, 1'b1, 32'd0);
		put(KIND_ACK, 3'd4, 1'b1, 32'd0);
		// zero window acts as one
		wait_drained();
		write_window(3'd0);
		put(KIND_SEND, 3'd0, 1'b0, 32'h0000_0020);
		put(KIND_ACK, 3'd7, 1'b1, 32'd0);
		put(KIND_ACK, 3'd6, 1'b1, 32'd0);
		put(KIND_SEND, 3'd0, 1'b0, 32'h0000_0040);
		put(KIND_SEND, 3'd0, 1'b0, 32'h0000_0080);

		for (int p = 0; p < 9; p++) begin
			wait_drained();
			write_window(plan[p]);
			calm = (p % 3 == 2);
			if (p == 0)
				hold_req = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++)
				drive_event(pick_event());
		end
		calm = 1'b0;
		wait_drained();

		$display("ran %0d items over %0d window settings, with a long output hold and drains",
			ledger.events_seen, phases_run);
		$display("results: %0d sent, %0d resent, %0d acked, %0d refused, %0d outside, %0d corrupt",
			ledger.by_action[ACT_SEND], ledger.by_action[ACT_RESEND],
			ledger.by_action[ACT_ACKED], ledger.by_action[ACT_REFUSED],
			ledger.by_action[ACT_OUTSIDE], ledger.by_action[ACT_CORRUPT]);
		if (ledger.errors == 0 && ledger.want_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== selective_repeat_sender_window.f =====
+incdir+rtl
rtl/srsw_pkg.sv
rtl/srsw_ifs.sv
rtl/srsw_ram.sv
rtl/srsw_ctrl.sv
rtl/selective_repeat_sender_window.sv
dv/srsw_tb_pkg.sv
dv/tb_top.sv
